>>> hdl/sfd_pkg.sv
package sfd_pkg;

   localparam logic [7:0] SYNC_BYTE_0 = 8'h10;
   localparam logic [7:0] SYNC_BYTE_1 = 8'h02;
   localparam logic [7:0] SYNC_BYTE_2 = 8'h93;
   localparam logic [7:0] ESCAPE_BYTE = 8'h10;
   localparam logic [7:0] LEN_MIN = 8'd12;
   localparam logic [7:0] LEN_MAX = 8'd234;
   localparam logic [7:0] HEADER_BYTES = 8'd11;
   localparam logic [7:0] SINGLE_FRAME_MAX = 8'd8;

   localparam logic [1:0] OP_START = 2'd0;
   localparam logic [1:0] OP_TAKE = 2'd1;
   localparam logic [1:0] OP_END = 2'd2;

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_END_GOOD = 2'd1;
   localparam logic [1:0] KIND_END_BAD = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } op_type;

endpackage

>>> hdl/stuffed_frame_deframer.sv
// channel | ports                                 | direction
// input   | req_valid req_ready req_rx_byte       | in
// result  | rsp_valid rsp_ready rsp_* fields      | out
// one byte accepted per cycle unless the queue is full; its op passes a queue slot, then the output register
// a byte passes the sync/length/escape parser, then a short op queue, then the sum/header unit
// synchronous active-high reset returns to sync hunt and empties the queue
// a stalled result holds the output register; the parser keeps taking bytes until the queue fills
module stuffed_frame_deframer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_record_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [7:0]  rsp_payload_index,
   output logic [23:0] rsp_group_number,
   output logic [7:0]  rsp_priority_res,
   output logic [7:0]  rsp_destination,
   output logic [7:0]  rsp_source,
   output logic [7:0]  rsp_payload_length,
   output logic        rsp_multi_frame
);

   logic            push, pop, empty, full;
   sfd_pkg::op_type push_op, pop_op;

   sfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .queue_full  (full),
      .push        (push),
      .push_op     (push_op)
   );

   sfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .pop_op  (pop_op),
      .empty   (empty),
      .full    (full)
   );

   sfd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .queue_empty        (empty),
      .pop_op             (pop_op),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_record_kind    (rsp_record_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_index  (rsp_payload_index),
      .rsp_group_number   (rsp_group_number),
      .rsp_priority_res   (rsp_priority_res),
      .rsp_destination    (rsp_destination),
      .rsp_source         (rsp_source),
      .rsp_payload_length (rsp_payload_length),
      .rsp_multi_frame    (rsp_multi_frame)
   );

endmodule

>>> hdl/sfd_front.sv
module sfd_front (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_rx_byte,
   input  logic           queue_full,
   output logic           push,
   output sfd_pkg::op_type push_op
);

   localparam logic [2:0] ST_SYNC0 = 3'd0;
   localparam logic [2:0] ST_SYNC1 = 3'd1;
   localparam logic [2:0] ST_SYNC2 = 3'd2;
   localparam logic [2:0] ST_LEN = 3'd3;
   localparam logic [2:0] ST_BODY = 3'd4;
   localparam logic [2:0] ST_ESC = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [7:0] left_ff, left_in;
   logic       accept;

   assign req_ready = !queue_full;
   assign accept = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      left_in = left_ff;
      push = 1'b0;
      push_op.kind = sfd_pkg::OP_TAKE;
      push_op.data = req_rx_byte;
      if (accept) begin
         unique case (state_ff)
            ST_SYNC0: begin
               if (req_rx_byte == sfd_pkg::SYNC_BYTE_0) state_in = ST_SYNC1;
            end
            ST_SYNC1: begin
               state_in = (req_rx_byte == sfd_pkg::SYNC_BYTE_1) ? ST_SYNC2 : ST_SYNC0;
            end
            ST_SYNC2: begin
               state_in = (req_rx_byte == sfd_pkg::SYNC_BYTE_2) ? ST_LEN : ST_SYNC0;
            end
            ST_LEN: begin
               if (req_rx_byte < sfd_pkg::LEN_MIN || req_rx_byte > sfd_pkg::LEN_MAX) begin
                  state_in = ST_SYNC0;
               end else begin
                  left_in = req_rx_byte;
                  push = 1'b1;
                  push_op.kind = sfd_pkg::OP_START;
                  state_in = ST_BODY;
               end
            end
            ST_BODY: begin
               if (left_ff != 8'd0) begin
                  left_in = left_ff - 8'd1;
                  if (req_rx_byte == sfd_pkg::ESCAPE_BYTE) begin
                     state_in = ST_ESC;
                  end else begin
                     push = 1'b1;
                  end
               end else begin
                  push = 1'b1;
                  push_op.kind = sfd_pkg::OP_END;
                  state_in = ST_SYNC0;
               end
            end
            ST_ESC: begin
               push = 1'b1;
               state_in = ST_BODY;
            end
            default: state_in = ST_SYNC0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SYNC0;
         left_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         left_ff <= left_in;
      end
   end

   ast_push_needs_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> accept)
      else $error("op pushed without an accepted transaction");

endmodule

>>> hdl/sfd_queue.sv
module sfd_queue #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sfd_pkg::op_type push_op,
   input  logic           pop,
   output sfd_pkg::op_type pop_op,
   output logic           empty,
   output logic           full
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   sfd_pkg::op_type slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full = (count_ff == FULL_COUNT);
   assign pop_op = slot_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      count_in = count_ff;
      if (push) wr_in = (wr_ff == LAST) ? '0 : wr_ff + AW'(1);
      if (pop) rd_in = (rd_ff == LAST) ? '0 : rd_ff + AW'(1);
      if (push && !pop) count_in = count_ff + CW'(1);
      else if (pop && !push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_op;
   end

   ast_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("queue count beyond depth");

   ast_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && !pop |-> !push)
      else $error("push into full queue");

   ast_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

>>> hdl/sfd_back.sv
module sfd_back (
   input  logic            clock,
   input  logic            reset,
   input  logic            queue_empty,
   input  sfd_pkg::op_type pop_op,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic [1:0]      rsp_record_kind,
   output logic [7:0]      rsp_payload_byte,
   output logic [7:0]      rsp_payload_index,
   output logic [23:0]     rsp_group_number,
   output logic [7:0]      rsp_priority_res,
   output logic [7:0]      rsp_destination,
   output logic [7:0]      rsp_source,
   output logic [7:0]      rsp_payload_length,
   output logic            rsp_multi_frame
);

   logic        valid_ff, valid_in;
   logic [7:0]  sum_ff, sum_in, sum_add;
   logic [7:0]  count_ff, count_in;
   logic [7:0]  prio_ff, prio_in;
   logic [23:0] group_ff, group_in;
   logic [7:0]  dest_ff, dest_in;
   logic [7:0]  src_ff, src_in;
   logic        produce;
   logic [7:0]  plen;

   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic [7:0]  index_ff, index_in;
   logic [23:0] ogroup_ff, ogroup_in;
   logic [7:0]  oprio_ff, oprio_in;
   logic [7:0]  odest_ff, odest_in;
   logic [7:0]  osrc_ff, osrc_in;
   logic [7:0]  olen_ff, olen_in;
   logic        omulti_ff, omulti_in;

   assign pop = !queue_empty && (!valid_ff || rsp_ready);
   assign sum_add = sum_ff + pop_op.data;
   assign plen = count_ff - sfd_pkg::HEADER_BYTES;

   always_comb begin
      sum_in = sum_ff;
      count_in = count_ff;
      prio_in = prio_ff;
      group_in = group_ff;
      dest_in = dest_ff;
      src_in = src_ff;
      produce = 1'b0;
      kind_in = sfd_pkg::KIND_PAYLOAD;
      byte_in = 8'd0;
      index_in = 8'd0;
      ogroup_in = 24'd0;
      oprio_in = 8'd0;
      odest_in = 8'd0;
      osrc_in = 8'd0;
      olen_in = 8'd0;
      omulti_in = 1'b0;
      if (pop) begin
         unique case (pop_op.kind)
            sfd_pkg::OP_START: begin
               sum_in = sfd_pkg::SYNC_BYTE_2 + pop_op.data;
               count_in = 8'd0;
            end
            sfd_pkg::OP_TAKE: begin
               sum_in = sum_add;
               count_in = count_ff + 8'd1;
               case (count_ff)
                  8'd0: prio_in = pop_op.data;
                  8'd1: group_in[7:0] = pop_op.data;
                  8'd2: group_in[15:8] = pop_op.data;
                  8'd3: group_in[23:16] = pop_op.data;
                  8'd4: dest_in = pop_op.data;
                  8'd5: src_in = pop_op.data;
                  default: ;
               endcase
               if (count_ff >= sfd_pkg::HEADER_BYTES) begin
                  produce = 1'b1;
                  byte_in = pop_op.data;
                  index_in = plen;
               end
            end
            sfd_pkg::OP_END: begin
               sum_in = sum_add;
               produce = 1'b1;
               kind_in = (sum_add == 8'd0) ? sfd_pkg::KIND_END_GOOD : sfd_pkg::KIND_END_BAD;
               ogroup_in = group_ff;
               oprio_in = prio_ff;
               odest_in = dest_ff;
               osrc_in = src_ff;
               olen_in = plen;
               omulti_in = (plen > sfd_pkg::SINGLE_FRAME_MAX);
            end
            default: ;
         endcase
      end
      valid_in = pop ? produce : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sum_ff <= 8'd0;
         count_ff <= 8'd0;
         prio_ff <= 8'd0;
         group_ff <= 24'd0;
         dest_ff <= 8'd0;
         src_ff <= 8'd0;
      end else begin
         valid_ff <= valid_in;
         sum_ff <= sum_in;
         count_ff <= count_in;
         prio_ff <= prio_in;
         group_ff <= group_in;
         dest_ff <= dest_in;
         src_ff <= src_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && produce) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         index_ff <= index_in;
         ogroup_ff <= ogroup_in;
         oprio_ff <= oprio_in;
         odest_ff <= odest_in;
         osrc_ff <= osrc_in;
         olen_ff <= olen_in;
         omulti_ff <= omulti_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_record_kind = kind_ff;
   assign rsp_payload_byte = byte_ff;
   assign rsp_payload_index = index_ff;
   assign rsp_group_number = ogroup_ff;
   assign rsp_priority_res = oprio_ff;
   assign rsp_destination = odest_ff;
   assign rsp_source = osrc_ff;
   assign rsp_payload_length = olen_ff;
   assign rsp_multi_frame = omulti_ff;

   ast_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |-> !pop)
      else $error("op taken while result stalled");

   ast_payload_fields_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff && kind_ff == sfd_pkg::KIND_PAYLOAD |-> olen_ff == 8'd0 && !omulti_ff)
      else $error("payload record carries end fields");

endmodule

>>> tb/stuffed_frame_deframer_tb.sv
module stuffed_frame_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int BYTE_TARGET = 1850;
   localparam int CALM_FROM = 1600;
   localparam int DRAIN_AT = 900;
   localparam int DIRECTED_ROWS = 27;

   localparam logic [1:0] ROW_PREDICT = 2'd0;
   localparam logic [1:0] ROW_NONE = 2'd1;
   localparam logic [1:0] ROW_RECORD = 2'd2;

   localparam logic [2:0] HUNT_SYNC0 = 3'd0;
   localparam logic [2:0] HUNT_SYNC1 = 3'd1;
   localparam logic [2:0] HUNT_SYNC2 = 3'd2;
   localparam logic [2:0] READ_LENGTH = 3'd3;
   localparam logic [2:0] READ_BODY = 3'd4;
   localparam logic [2:0] READ_ESCAPED = 3'd5;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  pbyte;
      logic [7:0]  pindex;
      logic [23:0] group;
      logic [7:0]  prio;
      logic [7:0]  dest;
      logic [7:0]  src;
      logic [7:0]  plen;
      logic        multi;
   } frame_record_type;

   typedef struct packed {
      logic [7:0]       rx;
      logic [1:0]       mode;
      frame_record_type rec;
   } stim_row_type;

   localparam frame_record_type NO_RECORD = '0;

   // broken syncs, a short length, then a minimum-length frame whose last count is an
   // escape, closed by a wrong checksum of 0x10
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{8'h10, ROW_NONE, NO_RECORD},
      '{8'h10, ROW_NONE, NO_RECORD},
      '{8'h10, ROW_NONE, NO_RECORD},
      '{8'h02, ROW_NONE, NO_RECORD},
      '{8'h10, ROW_NONE, NO_RECORD},
      '{8'h10, ROW_NONE, NO_RECORD},
      '{8'h02, ROW_NONE, NO_RECORD},
      '{8'h93, ROW_NONE, NO_RECORD},
      '{8'h0b, ROW_NONE, NO_RECORD},
      '{8'h10, ROW_NONE, NO_RECORD},
      '{8'h02, ROW_NONE, NO_RECORD},
      '{8'h93, ROW_NONE, NO_RECORD},
      '{8'h0c, ROW_NONE, NO_RECORD},
      '{8'hff, ROW_PREDICT, NO_RECORD},
      '{8'h01, ROW_PREDICT, NO_RECORD},
      '{8'h02, ROW_PREDICT, NO_RECORD},
      '{8'h03, ROW_PREDICT, NO_RECORD},
      '{8'h00, ROW_PREDICT, NO_RECORD},
      '{8'hff, ROW_PREDICT, NO_RECORD},
      '{8'h00, ROW_PREDICT, NO_RECORD},
      '{8'h00, ROW_PREDICT, NO_RECORD},
      '{8'h00, ROW_PREDICT, NO_RECORD},
      '{8'h00, ROW_PREDICT, NO_RECORD},
      '{8'h00, ROW_PREDICT, NO_RECORD},
      '{8'h10, ROW_PREDICT, NO_RECORD},
      '{8'hff, ROW_RECORD,
        '{sfd_pkg::KIND_PAYLOAD, 8'hff, 8'd0, 24'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0}},
      '{8'h10, ROW_RECORD,
        '{sfd_pkg::KIND_END_BAD, 8'd0, 8'd0, 24'h030201, 8'hff, 8'h00, 8'hff, 8'd1, 1'b0}}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_record_kind;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_payload_index;
   logic [23:0] rsp_group_number;
   logic [7:0]  rsp_priority_res;
   logic [7:0]  rsp_destination;
   logic [7:0]  rsp_source;
   logic [7:0]  rsp_payload_length;
   logic        rsp_multi_frame;

   stuffed_frame_deframer DUT (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // deframer state as seen from the byte stream
   logic [2:0]   parse_phase = HUNT_SYNC0;
   logic [7:0]   frame_sum = 8'd0;
   logic [7:0]   count_left = 8'd0;
   logic [7:0]   stored_bytes = 8'd0;
   logic [7:0]   hdr_priority = 8'd0;
   logic [23:0]  hdr_group = 24'd0;
   logic [7:0]   hdr_dest = 8'd0;
   logic [7:0]   hdr_source = 8'd0;

   frame_record_type record_q [$];
   int               mismatches = 0;
   int               bytes_sent = 0;
   int               quiet_cycles = 0;
   int               stall_left = 0;
   bit               idle_enable = 1'b1;

   function automatic bit store_message_byte(input logic [7:0] b,
                                             output frame_record_type rec);
      bit produced;
      produced = 1'b0;
      rec = NO_RECORD;
      frame_sum = frame_sum + b;
      case (stored_bytes)
         8'd0: hdr_priority = b;
         8'd1: hdr_group[7:0] = b;
         8'd2: hdr_group[15:8] = b;
         8'd3: hdr_group[23:16] = b;
         8'd4: hdr_dest = b;
         8'd5: hdr_source = b;
         default: ;
      endcase
      if (stored_bytes >= sfd_pkg::HEADER_BYTES) begin
         rec.kind = sfd_pkg::KIND_PAYLOAD;
         rec.pbyte = b;
         rec.pindex = stored_bytes - sfd_pkg::HEADER_BYTES;
         produced = 1'b1;
      end
      stored_bytes = stored_bytes + 8'd1;
      return produced;
   endfunction

   function automatic bit deframe_byte(input logic [7:0] b, output frame_record_type rec);
      bit         produced;
      logic [7:0] plen;
      produced = 1'b0;
      rec = NO_RECORD;
      unique case (parse_phase)
         HUNT_SYNC0: begin
            if (b == sfd_pkg::SYNC_BYTE_0) parse_phase = HUNT_SYNC1;
         end
         HUNT_SYNC1: begin
            parse_phase = (b == sfd_pkg::SYNC_BYTE_1) ? HUNT_SYNC2 : HUNT_SYNC0;
         end
         HUNT_SYNC2: begin
            if (b == sfd_pkg::SYNC_BYTE_2) begin
               frame_sum = b;
               parse_phase = READ_LENGTH;
            end else begin
               parse_phase = HUNT_SYNC0;
            end
         end
         READ_LENGTH: begin
            frame_sum = frame_sum + b;
            if (b < sfd_pkg::LEN_MIN || b > sfd_pkg::LEN_MAX) begin
               parse_phase = HUNT_SYNC0;
            end else begin
               count_left = b;
               stored_bytes = 8'd0;
               parse_phase = READ_BODY;
            end
         end
         READ_BODY: begin
            if (count_left != 8'd0) begin
               if (b == sfd_pkg::ESCAPE_BYTE) parse_phase = READ_ESCAPED;
               else produced = store_message_byte(b, rec);
               count_left = count_left - 8'd1;
            end else begin
               // checksum byte, never an escape
               frame_sum = frame_sum + b;
               plen = stored_bytes - sfd_pkg::HEADER_BYTES;
               rec.kind = (frame_sum == 8'd0) ? sfd_pkg::KIND_END_GOOD
                                              : sfd_pkg::KIND_END_BAD;
               rec.group = hdr_group;
               rec.prio = hdr_priority;
               rec.dest = hdr_dest;
               rec.src = hdr_source;
               rec.plen = plen;
               rec.multi = (plen > sfd_pkg::SINGLE_FRAME_MAX);
               produced = 1'b1;
               parse_phase = HUNT_SYNC0;
            end
         end
         READ_ESCAPED: begin
            produced = store_message_byte(b, rec);
            parse_phase = READ_BODY;
         end
         default: parse_phase = HUNT_SYNC0;
      endcase
      return produced;
   endfunction

   task automatic drive_byte(input logic [7:0] b);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      bytes_sent++;
   endtask

   task automatic send_byte(input logic [7:0] b);
      frame_record_type rec;
      drive_byte(b);
      if (deframe_byte(b, rec)) record_q.push_back(rec);
   endtask

   task automatic send_frame(input logic [7:0] len, input bit spoil);
      logic [7:0] sum;
      logic [7:0] b;
      int         i;
      send_byte(sfd_pkg::SYNC_BYTE_0);
      send_byte(sfd_pkg::SYNC_BYTE_1);
      send_byte(sfd_pkg::SYNC_BYTE_2);
      send_byte(len);
      sum = sfd_pkg::SYNC_BYTE_2 + len;
      i = 0;
      // an escape uses up one count of the length
      while (i < int'(len)) begin
         b = 8'($urandom_range(0, 255));
         if (b == sfd_pkg::ESCAPE_BYTE || $urandom_range(0, 11) == 0) begin
            send_byte(sfd_pkg::ESCAPE_BYTE);
            i++;
         end
         send_byte(b);
         sum = sum + b;
         i++;
      end
      b = -sum;
      if (spoil) b = b ^ 8'($urandom_range(1, 255));
      send_byte(b);
   endtask

   task automatic check_field(input string name, input logic [23:0] want,
                              input logic [23:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      frame_record_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (record_q.size() == 0) begin
               $error("unexpected transaction: record_kind %0d", rsp_record_kind);
               mismatches++;
            end else begin
               want = record_q.pop_front();
               check_field("record_kind", 24'(want.kind), 24'(rsp_record_kind));
               check_field("payload_byte", 24'(want.pbyte), 24'(rsp_payload_byte));
               check_field("payload_index", 24'(want.pindex), 24'(rsp_payload_index));
               check_field("group_number", want.group, rsp_group_number);
               check_field("priority_res", 24'(want.prio), 24'(rsp_priority_res));
               check_field("destination", 24'(want.dest), 24'(rsp_destination));
               check_field("source", 24'(want.src), 24'(rsp_source));
               check_field("payload_length", 24'(want.plen), 24'(rsp_payload_length));
               check_field("multi_frame", 24'(want.multi), 24'(rsp_multi_frame));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin
      frame_record_type rec;
      bit               produced;
      bit               drained;
      int               i;
      int               pick;
      logic [7:0]       len;
      logic [7:0]       b;
      drained = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_ROWS; i++) begin
         drive_byte(DIRECTED[i].rx);
         produced = deframe_byte(DIRECTED[i].rx, rec);
         case (DIRECTED[i].mode)
            ROW_PREDICT: if (produced) record_q.push_back(rec);
            ROW_RECORD: record_q.push_back(DIRECTED[i].rec);
            default: ;
         endcase
      end

      while (bytes_sent < BYTE_TARGET) begin
         idle_enable = (bytes_sent < CALM_FROM) && ($urandom_range(0, 3) != 0);
         if (!drained && bytes_sent >= DRAIN_AT) begin
            // hold the input until every pending transaction has come out
            drained = 1'b1;
            req_valid <= 1'b0;
            do @(posedge clock); while (record_q.size() != 0);
         end
         if ($urandom_range(0, 24) == 0) len = sfd_pkg::LEN_MAX;
         else if ($urandom_range(0, 9) == 0) len = sfd_pkg::LEN_MIN;
         else len = 8'($urandom_range(13, 40));
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            send_frame(len, 1'b0);
         end else if (pick < 72) begin
            send_frame(len, 1'b1);
         end else if (pick < 80) begin
            send_byte(sfd_pkg::SYNC_BYTE_0);
            if ($urandom_range(0, 1) == 0) begin
               b = 8'($urandom_range(0, 255));
               if (b == sfd_pkg::SYNC_BYTE_1) b = sfd_pkg::ESCAPE_BYTE;
               send_byte(b);
            end else begin
               send_byte(sfd_pkg::SYNC_BYTE_1);
               b = 8'($urandom_range(0, 255));
               if (b == sfd_pkg::SYNC_BYTE_2) b = sfd_pkg::ESCAPE_BYTE;
               send_byte(b);
            end
         end else if (pick < 88) begin
            send_byte(sfd_pkg::SYNC_BYTE_0);
            send_byte(sfd_pkg::SYNC_BYTE_1);
            send_byte(sfd_pkg::SYNC_BYTE_2);
            if ($urandom_range(0, 1) == 0)
               send_byte(8'($urandom_range(0, int'(sfd_pkg::LEN_MIN) - 1)));
            else
               send_byte(8'($urandom_range(int'(sfd_pkg::LEN_MAX) + 1, 255)));
         end else begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
         end
      end

      req_valid <= 1'b0;
      while (record_q.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (mismatches == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
hdl/sfd_pkg.sv
hdl/sfd_front.sv
hdl/sfd_queue.sv
hdl/sfd_back.sv
hdl/stuffed_frame_deframer.sv
tb/stuffed_frame_deframer_tb.sv
